/* rtl/plc_pkg.sv */
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants for the parallel line constraint block
// Angle format, arctangent table, CORDIC widths and channel payloads.
// ----------------------------------------------------------------------------
package plc_pkg;
	localparam int ANG_BITS    = 18;
	localparam int TOL_BITS    = 17;
	localparam int TABLE_LEN   = 32;
	localparam int COORD_BITS  = 32;
	localparam logic [ANG_BITS-1:0] ANG_PI      = 18'h20000;
	localparam logic [ANG_BITS-1:0] ANG_HALF_PI = 18'h10000;
	localparam logic [31:0] INVK_Q30 = 32'd652032874;

	typedef logic signed [ANG_BITS:0] zang_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_start_x;
		logic signed [COORD_BITS-1:0] first_start_y;
		logic signed [COORD_BITS-1:0] first_end_x;
		logic signed [COORD_BITS-1:0] first_end_y;
		logic signed [COORD_BITS-1:0] second_start_x;
		logic signed [COORD_BITS-1:0] second_start_y;
		logic signed [COORD_BITS-1:0] second_end_x;
		logic signed [COORD_BITS-1:0] second_end_y;
	} line_pair_t;

	typedef struct packed {
		logic                         lines_valid;
		logic [TOL_BITS-1:0]          angle_error;
		logic                         within_tolerance;
		logic signed [COORD_BITS-1:0] aligned_end_x;
		logic signed [COORD_BITS-1:0] aligned_end_y;
		logic                         end_saturated;
	} result_t;

	function automatic zang_t atan_entry(input int i);
		zang_t r;
		case (i)
			0: r = 19'sd32768;
			1: r = 19'sd19344;
			2: r = 19'sd10221;
			3: r = 19'sd5188;
			4: r = 19'sd2604;
			5: r = 19'sd1303;
			6: r = 19'sd652;
			7: r = 19'sd326;
			8: r = 19'sd163;
			9: r = 19'sd81;
			10: r = 19'sd41;
			11: r = 19'sd20;
			12: r = 19'sd10;
			13: r = 19'sd5;
			14: r = 19'sd3;
			15: r = 19'sd1;
			16: r = 19'sd1;
			default: r = 19'sd0;
		endcase
		return r;
	endfunction
endpackage

/* rtl/plc_if.sv */
// ----------------------------------------------------------------------------
// plc_if: valid/ready channel carrying a generic payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface plc_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/plc_cell.sv */
// ----------------------------------------------------------------------------
// plc_cell: one CORDIC iteration for both vectoring units and the rotator
// Registered; advances when enabled.
// ----------------------------------------------------------------------------
module plc_cell #(
	parameter int STAGE = 0,
	parameter int VW    = 40,
	parameter int RW    = 64
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [VW-1:0]  x1_in, y1_in, x2_in, y2_in,
	input  plc_pkg::zang_t        z1_in, z2_in,
	input  logic signed [RW-1:0]  rx_in, ry_in,
	input  plc_pkg::zang_t        rz_in,
	output logic signed [VW-1:0]  x1_out, y1_out, x2_out, y2_out,
	output plc_pkg::zang_t        z1_out, z2_out,
	output logic signed [RW-1:0]  rx_out, ry_out,
	output plc_pkg::zang_t        rz_out
);
	localparam plc_pkg::zang_t AT = plc_pkg::atan_entry(STAGE);

	always_ff @(posedge clk) begin
		if (en) begin
			if (y1_in > 0) begin
				x1_out <= x1_in + (y1_in >>> STAGE);
				y1_out <= y1_in - (x1_in >>> STAGE);
				z1_out <= z1_in + AT;
			end else begin
				x1_out <= x1_in - (y1_in >>> STAGE);
				y1_out <= y1_in + (x1_in >>> STAGE);
				z1_out <= z1_in - AT;
			end
			if (y2_in > 0) begin
				x2_out <= x2_in + (y2_in >>> STAGE);
				y2_out <= y2_in - (x2_in >>> STAGE);
				z2_out <= z2_in + AT;
			end else begin
				x2_out <= x2_in - (y2_in >>> STAGE);
				y2_out <= y2_in + (x2_in >>> STAGE);
				z2_out <= z2_in - AT;
			end
			if (!rz_in[plc_pkg::ANG_BITS]) begin
				rx_out <= rx_in - (ry_in >>> STAGE);
				ry_out <= ry_in + (rx_in >>> STAGE);
				rz_out <= rz_in - AT;
			end else begin
				rx_out <= rx_in + (ry_in >>> STAGE);
				ry_out <= ry_in - (rx_in >>> STAGE);
				rz_out <= rz_in + AT;
			end
		end
	end
endmodule

/* rtl/parallel_line_constraint_top.sv */
// ----------------------------------------------------------------------------
// parallel_line_constraint_top: parallelism check and alignment of two lines
// ----------------------------------------------------------------------------
// Usage: present two line segments (signed Q16.16) on in_ch; each transfer
// yields one result on out_ch: lines_valid, folded angle_error (pi/131072
// units), within_tolerance against the angle_tolerance register, and line 2's
// end rotated about its start by angle1 - angle2, saturated.
// Throughput: one item per cycle while the output is not stalled. The pipe has
// 2*CORDIC_STAGES + 6 register stages (CORDIC_STAGES capped at TABLE_LEN):
// difference, scale/fold, the vectoring cell chain, error fold, gain multiply,
// quadrant pre-rotation, the rotation cell chain and the output register.
// The whole pipe advances only when the output register is empty or taken;
// a stalled receiver holds every stage and deasserts ready.
// Reset clears all valid bits and loads tolerance 42. Write cfg_we with
// cfg_data while idle to change the tolerance.
// ----------------------------------------------------------------------------
module parallel_line_constraint_top #(
	parameter int CORDIC_STAGES = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [plc_pkg::TOL_BITS-1:0] cfg_data,
	plc_if.sink   in_ch,
	plc_if.source out_ch
);
	localparam int CB    = plc_pkg::COORD_BITS;
	localparam int GUARD = ((60 - CB) < 28) ? (60 - CB) : 28;
	localparam int VW    = CB + 1 + GUARD + 2;
	localparam int RW    = CB + 1 + GUARD + 3;
	localparam int NS    = (CORDIC_STAGES < plc_pkg::TABLE_LEN) ? CORDIC_STAGES
	                       : plc_pkg::TABLE_LEN;
	localparam int KW    = GUARD + 2;
	localparam logic [31:0] KVAL = (plc_pkg::INVK_Q30 + (32'd1 << (29 - GUARD)))
	                               >> (30 - GUARD);
	localparam int L     = 2 * NS + 6;
	localparam int AB    = plc_pkg::ANG_BITS;

	typedef logic signed [CB:0] d_t;

	logic [plc_pkg::TOL_BITS-1:0] tol_q;
	logic [L-1:0] vld_q;
	logic         adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= plc_pkg::TOL_BITS'(42);
		end else if (cfg_we) begin
			tol_q <= cfg_data;
		end
	end

	assign adv         = !vld_q[L-1] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[L-2:0], in_ch.valid};
		end
	end

	// stage 1: differences
	d_t dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [CB-1:0] px_s1, py_s1, ex_s1, ey_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx1_s1 <= d_t'(in_ch.data.first_end_x) - d_t'(in_ch.data.first_start_x);
			dy1_s1 <= d_t'(in_ch.data.first_end_y) - d_t'(in_ch.data.first_start_y);
			dx2_s1 <= d_t'(in_ch.data.second_end_x) - d_t'(in_ch.data.second_start_x);
			dy2_s1 <= d_t'(in_ch.data.second_end_y) - d_t'(in_ch.data.second_start_y);
			px_s1  <= in_ch.data.second_start_x;
			py_s1  <= in_ch.data.second_start_y;
			ex_s1  <= in_ch.data.second_end_x;
			ey_s1  <= in_ch.data.second_end_y;
		end
	end

	// stage 2: scale, fold to right half plane
	logic signed [VW-1:0] x1_s2, y1_s2, x2_s2, y2_s2;
	plc_pkg::zang_t       z1_s2, z2_s2;
	logic                 ok_s2;
	logic signed [VW-1:0] sx1, sy1, sx2, sy2;
	assign sx1 = VW'(dx1_s1) <<< GUARD;
	assign sy1 = VW'(dy1_s1) <<< GUARD;
	assign sx2 = VW'(dx2_s1) <<< GUARD;
	assign sy2 = VW'(dy2_s1) <<< GUARD;
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2 <= (dx1_s1 != 0 || dy1_s1 != 0) && (dx2_s1 != 0 || dy2_s1 != 0);
			x1_s2 <= sx1[VW-1] ? -sx1 : sx1;
			y1_s2 <= sx1[VW-1] ? -sy1 : sy1;
			z1_s2 <= sx1[VW-1] ? plc_pkg::zang_t'(plc_pkg::ANG_PI) : '0;
			x2_s2 <= sx2[VW-1] ? -sx2 : sx2;
			y2_s2 <= sx2[VW-1] ? -sy2 : sy2;
			z2_s2 <= sx2[VW-1] ? plc_pkg::zang_t'(plc_pkg::ANG_PI) : '0;
		end
	end

	// vectoring chain; rotation lanes idle there
	logic signed [VW-1:0] vx1 [NS+1], vy1 [NS+1], vx2 [NS+1], vy2 [NS+1];
	plc_pkg::zang_t       vz1 [NS+1], vz2 [NS+1];
	logic signed [RW-1:0] dumx [NS+1], dumy [NS+1];
	plc_pkg::zang_t       dumz [NS+1];
	logic signed [VW-1:0] rdx [NS+1], rdy [NS+1];
	logic signed [CB-1:0] cpx [NS+1], cpy [NS+1], cex [NS+1], cey [NS+1];
	logic                 cok [NS+1];
	assign vx1[0] = x1_s2; assign vy1[0] = y1_s2; assign vz1[0] = z1_s2;
	assign vx2[0] = x2_s2; assign vy2[0] = y2_s2; assign vz2[0] = z2_s2;
	assign dumx[0] = '0; assign dumy[0] = '0; assign dumz[0] = '0;
	assign cpx[0] = px_s1; assign cpy[0] = py_s1;
	assign cex[0] = ex_s1; assign cey[0] = ey_s1;
	assign cok[0] = ok_s2;
	assign rdx[0] = VW'(dx2_s1); assign rdy[0] = VW'(dy2_s1);

	logic signed [CB-1:0] px_s2, py_s2, ex_s2, ey_s2;
	logic signed [VW-1:0] qdx_s2, qdy_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2 <= px_s1; py_s2 <= py_s1; ex_s2 <= ex_s1; ey_s2 <= ey_s1;
			qdx_s2 <= rdx[0]; qdy_s2 <= rdy[0];
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_vec
		plc_cell #(.STAGE(i), .VW(VW), .RW(RW)) u_cell (
			.clk(clk), .en(adv),
			.x1_in(vx1[i]), .y1_in(vy1[i]), .x2_in(vx2[i]), .y2_in(vy2[i]),
			.z1_in(vz1[i]), .z2_in(vz2[i]),
			.rx_in(dumx[i]), .ry_in(dumy[i]), .rz_in(dumz[i]),
			.x1_out(vx1[i+1]), .y1_out(vy1[i+1]), .x2_out(vx2[i+1]),
			.y2_out(vy2[i+1]), .z1_out(vz1[i+1]), .z2_out(vz2[i+1]),
			.rx_out(dumx[i+1]), .ry_out(dumy[i+1]), .rz_out(dumz[i+1]));
		logic signed [CB-1:0] px_q, py_q, ex_q, ey_q;
		logic signed [VW-1:0] dx_q, dy_q;
		logic                 ok_q;
		always_ff @(posedge clk) begin
			if (adv) begin
				px_q <= (i == 0) ? px_s2 : cpx[i];
				py_q <= (i == 0) ? py_s2 : cpy[i];
				ex_q <= (i == 0) ? ex_s2 : cex[i];
				ey_q <= (i == 0) ? ey_s2 : cey[i];
				dx_q <= (i == 0) ? qdx_s2 : rdx[i];
				dy_q <= (i == 0) ? qdy_s2 : rdy[i];
				ok_q <= cok[i];
			end
		end
		assign cpx[i+1] = px_q; assign cpy[i+1] = py_q;
		assign cex[i+1] = ex_q; assign cey[i+1] = ey_q;
		assign rdx[i+1] = dx_q; assign rdy[i+1] = dy_q;
		assign cok[i+1] = ok_q;
	end

	// stage 3: fold error, rotation angle
	logic [AB-1:0] diff, e1, e2;
	assign diff = AB'(vz1[NS]) - AB'(vz2[NS]);
	assign e1   = (diff > plc_pkg::ANG_PI) ? (AB'(0) - diff) : diff;
	assign e2   = (e1 > plc_pkg::ANG_HALF_PI) ? (plc_pkg::ANG_PI - e1) : e1;
	logic [plc_pkg::TOL_BITS-1:0] err_s3;
	plc_pkg::zang_t rot_s3;
	logic ok_s3;
	logic signed [CB-1:0] px_s3, py_s3, ex_s3, ey_s3;
	logic signed [VW-1:0] dx_s3, dy_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s3 <= plc_pkg::TOL_BITS'(e2);
			rot_s3 <= plc_pkg::zang_t'(signed'(diff));
			ok_s3  <= cok[NS];
			px_s3 <= cpx[NS]; py_s3 <= cpy[NS]; ex_s3 <= cex[NS]; ey_s3 <= cey[NS];
			dx_s3 <= rdx[NS]; dy_s3 <= rdy[NS];
		end
	end

	// stage 4: gain multiply
	logic signed [RW-1:0] mx_s4, my_s4;
	logic signed [KW-1:0] kk;
	assign kk = KW'(KVAL);
	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s4 <= RW'(dx_s3) * RW'(kk);
			my_s4 <= RW'(dy_s3) * RW'(kk);
		end
	end
	logic [plc_pkg::TOL_BITS-1:0] err_s4;
	plc_pkg::zang_t rot_s4;
	logic ok_s4;
	logic signed [CB-1:0] px_s4, py_s4, ex_s4, ey_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s4 <= err_s3; rot_s4 <= rot_s3; ok_s4 <= ok_s3;
			px_s4 <= px_s3; py_s4 <= py_s3; ex_s4 <= ex_s3; ey_s4 <= ey_s3;
		end
	end

	// stage 5: quadrant pre-rotation
	logic signed [RW-1:0] qx_s5, qy_s5;
	plc_pkg::zang_t qz_s5;
	localparam plc_pkg::zang_t ZPI = plc_pkg::zang_t'(plc_pkg::ANG_PI);
	localparam plc_pkg::zang_t ZHP = plc_pkg::zang_t'(plc_pkg::ANG_HALF_PI);
	always_ff @(posedge clk) begin
		if (adv) begin
			if (rot_s4 > ZHP) begin
				qx_s5 <= -mx_s4; qy_s5 <= -my_s4; qz_s5 <= rot_s4 - ZPI;
			end else if (rot_s4 < -ZHP) begin
				qx_s5 <= -mx_s4; qy_s5 <= -my_s4; qz_s5 <= rot_s4 + ZPI;
			end else begin
				qx_s5 <= mx_s4; qy_s5 <= my_s4; qz_s5 <= rot_s4;
			end
		end
	end

	// rotation chain; vectoring lanes idle there
	logic signed [RW-1:0] wx [NS+1], wy [NS+1];
	plc_pkg::zang_t       wz [NS+1];
	logic signed [VW-1:0] ax [NS+1], ay [NS+1], bx [NS+1], by [NS+1];
	plc_pkg::zang_t       az [NS+1], bz [NS+1];
	logic [plc_pkg::TOL_BITS-1:0] ce [NS+2];
	logic                 ck [NS+2];
	logic signed [CB-1:0] kpx [NS+2], kpy [NS+2], kex [NS+2], key [NS+2];
	assign wx[0] = qx_s5; assign wy[0] = qy_s5; assign wz[0] = qz_s5;
	assign ax[0] = '0; assign ay[0] = '0; assign bx[0] = '0; assign by[0] = '0;
	assign az[0] = '0; assign bz[0] = '0;
	assign ce[0] = err_s4; assign ck[0] = ok_s4;
	assign kpx[0] = px_s4; assign kpy[0] = py_s4; assign kex[0] = ex_s4;
	assign key[0] = ey_s4;

	for (genvar j = 0; j < NS + 1; j++) begin : g_side
		logic [plc_pkg::TOL_BITS-1:0] e_q;
		logic k_q;
		logic signed [CB-1:0] a_q, b_q, c_q, d_q;
		always_ff @(posedge clk) begin
			if (adv) begin
				e_q <= ce[j]; k_q <= ck[j];
				a_q <= kpx[j]; b_q <= kpy[j]; c_q <= kex[j]; d_q <= key[j];
			end
		end
		assign ce[j+1] = e_q; assign ck[j+1] = k_q;
		assign kpx[j+1] = a_q; assign kpy[j+1] = b_q;
		assign kex[j+1] = c_q; assign key[j+1] = d_q;
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		plc_cell #(.STAGE(i), .VW(VW), .RW(RW)) u_cell (
			.clk(clk), .en(adv),
			.x1_in(ax[i]), .y1_in(ay[i]), .x2_in(bx[i]), .y2_in(by[i]),
			.z1_in(az[i]), .z2_in(bz[i]),
			.rx_in(wx[i]), .ry_in(wy[i]), .rz_in(wz[i]),
			.x1_out(ax[i+1]), .y1_out(ay[i+1]), .x2_out(bx[i+1]),
			.y2_out(by[i+1]), .z1_out(az[i+1]), .z2_out(bz[i+1]),
			.rx_out(wx[i+1]), .ry_out(wy[i+1]), .rz_out(wz[i+1]));
	end

	// final: round, add pivot, saturate; invalid lines pass line 2's end unchanged
	localparam logic signed [RW-1:0] HALF = RW'(1) <<< (GUARD - 1);
	localparam logic signed [RW-1:0] HI   = (RW'(1) <<< (CB - 1)) - RW'(1);
	localparam logic signed [RW-1:0] LO   = -HI - RW'(1);
	logic signed [RW-1:0] fx, fy;
	assign fx = ((wx[NS] + HALF) >>> GUARD) + RW'(kpx[NS+1]);
	assign fy = ((wy[NS] + HALF) >>> GUARD) + RW'(kpy[NS+1]);

	typedef struct packed {
		logic          lines_valid;
		logic [16:0]   angle_error;
		logic          within_tolerance;
		logic [CB-1:0] aligned_end_x;
		logic [CB-1:0] aligned_end_y;
		logic          end_saturated;
	} res_t;
	res_t res_q;
	logic sx_hi, sx_lo, sy_hi, sy_lo;
	assign sx_hi = fx > HI; assign sx_lo = fx < LO;
	assign sy_hi = fy > HI; assign sy_lo = fy < LO;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ck[NS+1]) begin
				res_q.lines_valid      <= 1'b1;
				res_q.angle_error      <= ce[NS+1];
				res_q.within_tolerance <= ce[NS+1] <= tol_q;
				res_q.aligned_end_x    <= sx_hi ? CB'(HI) : sx_lo ? CB'(LO) : CB'(fx);
				res_q.aligned_end_y    <= sy_hi ? CB'(HI) : sy_lo ? CB'(LO) : CB'(fy);
				res_q.end_saturated    <= sx_hi || sx_lo || sy_hi || sy_lo;
			end else begin
				res_q.lines_valid      <= 1'b0;
				res_q.angle_error      <= 17'h10000;
				res_q.within_tolerance <= 1'b0;
				res_q.aligned_end_x    <= kex[NS+1];
				res_q.aligned_end_y    <= key[NS+1];
				res_q.end_saturated    <= 1'b0;
			end
		end
	end

	assign out_ch.valid                 = vld_q[L-1];
	assign out_ch.data.lines_valid      = res_q.lines_valid;
	assign out_ch.data.angle_error      = res_q.angle_error;
	assign out_ch.data.within_tolerance = res_q.within_tolerance;
	assign out_ch.data.aligned_end_x    = res_q.aligned_end_x;
	assign out_ch.data.aligned_end_y    = res_q.aligned_end_y;
	assign out_ch.data.end_saturated    = res_q.end_saturated;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(vld_q))
		else $error("pipe moved during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("ready low with empty output");
	a_tol: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.within_tolerance |-> out_ch.data.lines_valid)
		else $error("tolerance set on invalid lines");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.data.lines_valid |-> !out_ch.data.end_saturated)
		else $error("saturation flag on invalid lines");
endmodule
